// ===== hdl/bdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdc_pkg
// shared types and constants for the button debounce and click classifier
// ----------------------------------------------------------------------------
`default_nettype none

package bdc_pkg;

  // field widths fixed by the interface
  localparam int NOW_W    = 48;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  // thresholds are kept in microseconds: 65535 ms * 1000 fits in 26 bits
  localparam int THR_W    = 26;
  localparam logic [THR_W-1:0] US_PER_MS = THR_W'(1000);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'd1;

  // reset thresholds in microseconds
  localparam logic [THR_W-1:0] DEBOUNCE_RST_US   = THR_W'(20000);
  localparam logic [THR_W-1:0] LONG_PRESS_RST_US = THR_W'(1000000);

  typedef enum logic [1:0] {
    EDGE_NONE    = 2'd0,
    EDGE_PRESS   = 2'd1,
    EDGE_RELEASE = 2'd2
  } edge_t;

  typedef enum logic [1:0] {
    CLICK_NONE  = 2'd0,
    CLICK_SHORT = 2'd1,
    CLICK_LONG  = 2'd2
  } click_t;

  // single-bit state of the classifier
  typedef struct packed {
    logic last_raw;
    logic stable_pressed;
    logic long_reported;
  } bdc_flags_t;

endpackage

`default_nettype wire

// ===== hdl/bdc_step.sv =====
// ----------------------------------------------------------------------------
// bdc_step
// per-sample next-state and result logic of the debounce and click classifier
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_step
  import bdc_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  wire logic                 raw,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire logic [THR_W-1:0]     debounce_us,
  input  wire logic [THR_W-1:0]     long_press_us,
  input  wire bdc_flags_t           flags,
  input  wire logic [TIME_BITS-1:0] last_change,
  input  wire logic [TIME_BITS-1:0] press_start,
  output bdc_flags_t                flags_nxt,
  output logic [TIME_BITS-1:0]      last_change_nxt,
  output logic [TIME_BITS-1:0]      press_start_nxt,
  output edge_t                     edge_res,
  output click_t                    click
);

  logic [TIME_BITS-1:0] el_change;
  logic [TIME_BITS-1:0] el_press;
  logic                 raw_chg;
  logic                 settle;

  always_comb begin
    raw_chg   = raw != flags.last_raw;
    el_change = now - last_change;
    settle    = !raw_chg && (raw != flags.stable_pressed) &&
                (el_change >= TIME_BITS'(debounce_us));

    flags_nxt       = flags;
    last_change_nxt = last_change;
    press_start_nxt = press_start;
    edge_res        = EDGE_NONE;
    click           = CLICK_NONE;

    // debounce
    if (raw_chg) begin
      flags_nxt.last_raw = raw;
      last_change_nxt    = now;
    end else if (settle) begin
      flags_nxt.stable_pressed = raw;
      edge_res = raw ? EDGE_PRESS : EDGE_RELEASE;
    end

    // click class
    if (edge_res == EDGE_PRESS) begin
      press_start_nxt         = now;
      flags_nxt.long_reported = 1'b0;
    end else if (edge_res == EDGE_RELEASE && !flags.long_reported) begin
      click = CLICK_SHORT;
    end

    // held time is zero on the press sample itself
    el_press = (edge_res == EDGE_PRESS) ? '0 : (now - press_start);

    if (click == CLICK_NONE && flags_nxt.stable_pressed && !flags_nxt.long_reported &&
        el_press >= TIME_BITS'(long_press_us)) begin
      flags_nxt.long_reported = 1'b1;
      click = CLICK_LONG;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/button_debounce_click_classifier.sv =====
// ----------------------------------------------------------------------------
// button_debounce_click_classifier
// debounces a sampled button level and classifies short and long clicks
// ----------------------------------------------------------------------------
// Each input word is one raw button sample with a microsecond timestamp and
// gives exactly one result word (debounced edge and click class). A word is
// taken every clock cycle when the output side keeps up; a sample goes from
// the input register through the single-pass step logic into the result
// register. Timestamps are kept modulo 2^TIME_BITS, so a wrapping time
// counter is fine. Thresholds are written in milliseconds and converted to
// microseconds once, when the register is written. Reset assumes a released
// button.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_click_classifier
  import bdc_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  // sample words
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_raw_pressed,
  input  wire logic [NOW_W-1:0]     in_now_us,
  // result words
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_edge_res,
  output logic [1:0]                out_click
);

  // thresholds in microseconds
  logic [THR_W-1:0]     debounce_us_r;
  logic [THR_W-1:0]     long_press_us_r;
  logic [THR_W-1:0]     cfg_us;

  // input register
  logic                 s1_valid_r;
  logic                 s1_raw_r;
  logic [TIME_BITS-1:0] s1_now_r;

  // classifier state
  bdc_flags_t           flags_r;
  bdc_flags_t           flags_nxt;
  logic [TIME_BITS-1:0] last_change_r;
  logic [TIME_BITS-1:0] last_change_nxt;
  logic [TIME_BITS-1:0] press_start_r;
  logic [TIME_BITS-1:0] press_start_nxt;

  // result register
  logic                 out_valid_r;
  edge_t                out_edge_r;
  click_t               out_click_r;
  edge_t                res_edge;
  click_t               res_click;

  logic                 adv;      // input register moves into result register
  logic                 in_take;

  // ms to us; 16 bit times constant fits the threshold width
  assign cfg_us = THR_W'(cfg_wdata) * US_PER_MS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_us_r   <= DEBOUNCE_RST_US;
      long_press_us_r <= LONG_PRESS_RST_US;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE:   debounce_us_r   <= cfg_us;
        CFG_LONG_PRESS: long_press_us_r <= cfg_us;
        default:        ;
      endcase
    end
  end

  // result register frees up when empty or being taken
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // sample payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_raw_r <= in_raw_pressed;
      s1_now_r <= TIME_BITS'(in_now_us);
    end
  end

  bdc_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .raw             (s1_raw_r),
    .now             (s1_now_r),
    .debounce_us     (debounce_us_r),
    .long_press_us   (long_press_us_r),
    .flags           (flags_r),
    .last_change     (last_change_r),
    .press_start     (press_start_r),
    .flags_nxt       (flags_nxt),
    .last_change_nxt (last_change_nxt),
    .press_start_nxt (press_start_nxt),
    .edge_res        (res_edge),
    .click           (res_click)
  );

  // state commits when the sample's result is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r       <= '0;
      last_change_r <= '0;
      press_start_r <= '0;
    end else if (adv) begin
      flags_r       <= flags_nxt;
      last_change_r <= last_change_nxt;
      press_start_r <= press_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_edge_r  <= res_edge;
      out_click_r <= res_click;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_edge_res = out_edge_r;
  assign out_click    = out_click_r;

  // a press never comes with a short click
  a_press_no_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_edge_r == EDGE_PRESS |-> out_click_r != CLICK_SHORT)
    else $error("short click on a press edge");

  // a release never comes with a long click
  a_release_no_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_edge_r == EDGE_RELEASE |-> out_click_r != CLICK_LONG)
    else $error("long click on a release edge");

  // a press edge leaves the stable state pressed
  a_press_sets_stable: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_edge == EDGE_PRESS |=> flags_r.stable_pressed)
    else $error("press edge without pressed stable state");

  // a long click marks the press as reported
  a_long_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_click == CLICK_LONG |=> flags_r.long_reported)
    else $error("long click not recorded");

  // input stalls only while the input register is full
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty input register");

endmodule

`default_nettype wire
